// ===== hw/rtl/olce_pkg.sv =====
// shared constants, codes and cell command type for the ordered character list engine
// no dependencies; used by olce_cell and ordered_char_list_engine
`default_nettype none

package olce_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int MAX_DEPTH     = 256;
   // wide enough for any slot number or count up to MAX_DEPTH
   localparam int SLOT_W        = $clog2(MAX_DEPTH + 1);
   // cells examined per scan cycle of a search
   localparam int SCAN_LANES    = 8;

   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_SEARCH = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [1:0] STATUS_BAD_POS = 2'd3;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_REMOVE = 2'd3
   } olce_cmd_kind_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      olce_cmd_kind_type   kind;
      logic [7:0]          value;
      logic [SLOT_W-1:0]   slot;
      logic [SLOT_W-1:0]   count;
   } olce_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/olce_cell.sv =====
// one storage cell of the list chain: holds a byte, takes from a neighbor on shifts
// depends on olce_pkg for the command struct
`default_nettype none

module olce_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                  clock,
   input  wire olce_pkg::olce_cmd_type cmd,
   input  wire logic [7:0]            left_value,
   input  wire logic [7:0]            right_value,
   output logic      [7:0]            value,
   output logic                       hit
);

   localparam int SW = olce_pkg::SLOT_W;
   localparam logic [SW-1:0] MY_SLOT = SW'(INDEX);

   logic [7:0] value_ff;
   logic [7:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.kind)
         olce_pkg::CMD_APPEND: begin
            if (MY_SLOT == cmd.slot) value_in = cmd.value;
         end
         olce_pkg::CMD_INSERT: begin
            if (MY_SLOT == cmd.slot) begin
               value_in = cmd.value;
            end else if (MY_SLOT > cmd.slot && MY_SLOT <= cmd.count) begin
               value_in = left_value;
            end
         end
         olce_pkg::CMD_REMOVE: value_in = right_value;
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   // only occupied cells may match
   assign hit   = (value_ff == cmd.value) && (MY_SLOT < cmd.count);

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_char_list_engine.sv =====
// top level of the ordered character list engine: control, search scan, result register
// depends on olce_pkg and olce_cell
//
//   channel   dir   handshake               payload
//   req       in    req_tvalid/req_tready   func, value, position
//   rsp       out   rsp_tvalid/rsp_tready   status, found, found_index, occupancy
//
// append, insert, remove and a search of an empty list finish in the cycle they are
// accepted; the chain of cells shifts in that same cycle
// in a search the match flags are registered, then scanned eight cells per cycle until the
// first hit or the end of the occupied cells; the scan ends only once the output is free
// synchronous reset empties the list; cell contents are not cleared
// req_tready is low in reset, during a scan and while a result is held that rsp_tready
// does not take
`default_nettype none

module ordered_char_list_engine #(
   parameter int DEPTH = olce_pkg::DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] func, [9:2] value, [14:10] position, [15] zero
   input  wire logic [15:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [2] found, [6:3] found_index, [11:7] occupancy, [15:12] zero
   output logic [15:0]      rsp_tdata
);

   localparam int SW    = olce_pkg::SLOT_W;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int LANES = (DEPTH < olce_pkg::SCAN_LANES) ? DEPTH : olce_pkg::SCAN_LANES;
   localparam int LW    = $clog2(LANES);
   localparam int BW    = $clog2(DEPTH + LANES + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   logic [1:0] req_func;
   logic [7:0] req_value;
   logic [4:0] req_position;

   assign req_func     = req_tdata[1:0];
   assign req_value    = req_tdata[9:2];
   assign req_position = req_tdata[14:10];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [DEPTH-1:0] scan_hit_ff, scan_hit_in;
   logic [BW-1:0] scan_base_ff, scan_base_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_found_ff, rsp_found_in;
   logic [3:0] rsp_index_ff, rsp_index_in;
   logic [4:0] rsp_occ_ff, rsp_occ_in;

   logic out_free;
   logic accept;

   olce_pkg::olce_cmd_type cmd;
   logic [7:0] cell_value [DEPTH];
   logic [DEPTH-1:0] cell_hit;

   // decode of the accepted request
   logic [1:0]    dec_status;
   logic [CW-1:0] dec_count;
   logic          dec_scan;

   // scan window
   logic [LANES-1:0] scan_low;
   logic [LW-1:0]    pe_idx;
   logic             pe_any;
   logic [BW-1:0]    scan_next_base;
   logic             scan_end;
   logic             scan_done;

   logic [SW-1:0] cnt_ext;
   logic [SW-1:0] pos_ext;
   logic          full;
   logic          empty;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !reset && (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign cnt_ext = SW'(count_ff);
   assign pos_ext = SW'(req_position);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);

   always_comb begin
      cmd.kind   = olce_pkg::CMD_HOLD;
      cmd.value  = req_value;
      cmd.slot   = cnt_ext;
      cmd.count  = cnt_ext;
      dec_status = olce_pkg::STATUS_OK;
      dec_count  = count_ff;
      dec_scan   = 1'b0;
      unique case (req_func)
         olce_pkg::FUNC_APPEND: begin
            if (full) begin
               dec_status = olce_pkg::STATUS_FULL;
            end else begin
               if (accept) cmd.kind = olce_pkg::CMD_APPEND;
               dec_count = count_ff + CW'(1);
            end
         end
         olce_pkg::FUNC_INSERT: begin
            if (full) begin
               dec_status = olce_pkg::STATUS_FULL;
            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
               dec_status = olce_pkg::STATUS_BAD_POS;
            end else begin
               if (accept) cmd.kind = olce_pkg::CMD_INSERT;
               cmd.slot  = pos_ext;
               dec_count = count_ff + CW'(1);
            end
         end
         olce_pkg::FUNC_REMOVE: begin
            if (empty) begin
               dec_status = olce_pkg::STATUS_EMPTY;
            end else begin
               if (accept) cmd.kind = olce_pkg::CMD_REMOVE;
               dec_count = count_ff - CW'(1);
            end
         end
         olce_pkg::FUNC_SEARCH: begin
            if (empty) begin
               dec_status = olce_pkg::STATUS_EMPTY;
            end else begin
               dec_scan = 1'b1;
            end
         end
         default: dec_status = olce_pkg::STATUS_OK;
      endcase
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [7:0] left_value;
      logic [7:0] right_value;
      if (g == 0) begin : g_first
         assign left_value = req_value;
      end else begin : g_mid_l
         assign left_value = cell_value[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_value = cell_value[g];
      end else begin : g_mid_r
         assign right_value = cell_value[g+1];
      end
      olce_cell #(
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[g]),
         .hit         (cell_hit[g])
      );
   end

   assign scan_low       = scan_hit_ff[LANES-1:0];
   assign scan_next_base = scan_base_ff + BW'(LANES);
   assign scan_end       = scan_next_base >= BW'(count_ff);

   always_comb begin
      pe_idx = '0;
      pe_any = |scan_low;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (scan_low[i]) pe_idx = LW'(i);
      end
   end

   assign scan_done = (state_ff == ST_SCAN) && (pe_any || scan_end) && out_free;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_hit_in   = scan_hit_ff;
      scan_base_in  = scan_base_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_occ_in    = rsp_occ_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (dec_scan) begin
                  state_in     = ST_SCAN;
                  scan_hit_in  = cell_hit;
                  scan_base_in = '0;
               end else begin
                  count_in      = dec_count;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dec_status;
                  rsp_found_in  = 1'b0;
                  rsp_index_in  = '0;
                  rsp_occ_in    = 5'(dec_count);
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = olce_pkg::STATUS_OK;
               rsp_found_in  = pe_any;
               rsp_index_in  = pe_any ? 4'(scan_base_ff + BW'(pe_idx)) : 4'd0;
               rsp_occ_in    = 5'(count_ff);
            end else if (!pe_any && !scan_end) begin
               scan_hit_in  = scan_hit_ff >> LANES;
               scan_base_in = scan_next_base;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_hit_ff   <= scan_hit_in;
      scan_base_ff  <= scan_base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_occ_ff, rsp_index_ff, rsp_found_ff, rsp_status_ff};

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_search_scans : assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == olce_pkg::FUNC_SEARCH && !empty) |=> state_ff == ST_SCAN)
      else $error("search of a non-empty list did not start a scan");

   a_occ_tracks_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_occ_ff == 5'(count_ff))
      else $error("pending result occupancy differs from entry count");

   a_found_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> rsp_status_ff == olce_pkg::STATUS_OK)
      else $error("hit reported with a failing status");

endmodule

`default_nettype wire

// ===== tb/ordered_char_list_engine_tb.sv =====
// self-checking testbench for ordered_char_list_engine: directed and random list traffic
// depends on olce_pkg and the ordered_char_list_engine rtl; predicts every response in place
`default_nettype none

module ordered_char_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = olce_pkg::DEPTH_DEFAULT;

   typedef struct {
      logic [1:0] status;
      logic       found;
      logic [3:0] found_index;
      logic [4:0] occupancy;
   } list_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [1:0] func, [9:2] value, [14:10] position, [15] zero
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [1:0] status, [2] found, [6:3] found_index, [11:7] occupancy, [15:12] zero
   logic [15:0] rsp_tdata;

   // shadow copy of the list held by the block
   logic [7:0]   shadow_cells [DEPTH];
   int           shadow_count;
   list_rsp_type pending_results [$];

   int error_count;
   int burst_left;
   bit sender_gaps_on;
   bit receiver_stalls_on;
   bit hold_off_request;

   ordered_char_list_engine #(.DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("** ordered_char_list_engine: FAILED **");
      $finish;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 40)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   // applies one request to the shadow list and returns the response it must produce
   function automatic list_rsp_type apply_list_op(input logic [1:0] func,
                                                  input logic [7:0] value,
                                                  input logic [4:0] position);
      list_rsp_type r;
      int i;
      r.status = olce_pkg::STATUS_OK;
      r.found = 1'b0;
      r.found_index = '0;
      case (func)
         olce_pkg::FUNC_APPEND: begin
            if (shadow_count >= DEPTH) begin
               r.status = olce_pkg::STATUS_FULL;
            end else begin
               shadow_cells[shadow_count] = value;
               shadow_count++;
            end
         end
         olce_pkg::FUNC_INSERT: begin
            if (shadow_count >= DEPTH) begin
               r.status = olce_pkg::STATUS_FULL;
            end else if (position == 0 || position > shadow_count) begin
               r.status = olce_pkg::STATUS_BAD_POS;
            end else begin
               for (i = shadow_count; i > position; i--)
                  shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[position] = value;
               shadow_count++;
            end
         end
         olce_pkg::FUNC_REMOVE: begin
            if (shadow_count == 0) begin
               r.status = olce_pkg::STATUS_EMPTY;
            end else begin
               for (i = 0; i + 1 < shadow_count; i++)
                  shadow_cells[i] = shadow_cells[i+1];
               shadow_count--;
            end
         end
         default: begin
            if (shadow_count == 0) begin
               r.status = olce_pkg::STATUS_EMPTY;
            end else begin
               for (i = 0; i < shadow_count; i++) begin
                  if (!r.found && shadow_cells[i] == value) begin
                     r.found = 1'b1;
                     r.found_index = i[3:0];
                  end
               end
            end
         end
      endcase
      r.occupancy = shadow_count[4:0];
      return r;
   endfunction

   // offers one request, waits for the transfer, then records the predicted response
   task automatic send_request(input logic [1:0] func, input logic [7:0] value,
                               input logic [4:0] position);
      int gap;
      if (sender_gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, position, value, func};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_list_op(func, value, position));
   endtask

   task automatic idle_request_bus();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // receiver: switches among random stall patterns, or holds off on request
   initial begin
      int mode;
      int mode_left;
      int phase;
      int hold_left;
      bit hold_taken;
      mode = 0;
      mode_left = 0;
      phase = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         phase++;
         if (hold_off_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!receiver_stalls_on) begin
            rsp_tready <= 1'b1;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (phase % 4 == 0);
               default: rsp_tready <= (phase % 8 < 5);
            endcase
         end
      end
   end

   // response checker
   initial begin
      list_rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_error($sformatf("response transfer with none pending, data %h", rsp_tdata));
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[1:0] !== want.status)
                  report_error($sformatf("status got %0d want %0d", rsp_tdata[1:0], want.status));
               if (rsp_tdata[2] !== want.found)
                  report_error($sformatf("found got %0d want %0d", rsp_tdata[2], want.found));
               if (rsp_tdata[6:3] !== want.found_index)
                  report_error($sformatf("found_index got %0d want %0d", rsp_tdata[6:3],
                                         want.found_index));
               if (rsp_tdata[11:7] !== want.occupancy)
                  report_error($sformatf("occupancy got %0d want %0d", rsp_tdata[11:7],
                                         want.occupancy));
            end
         end
      end
   end

   task automatic test_directed_cases();
      send_request(olce_pkg::FUNC_REMOVE, 8'h00, 5'd0);   // remove from empty
      send_request(olce_pkg::FUNC_SEARCH, 8'hFF, 5'd0);   // search empty
      send_request(olce_pkg::FUNC_INSERT, 8'h11, 5'd0);   // empty list: every position bad
      send_request(olce_pkg::FUNC_INSERT, 8'h22, 5'd1);
      send_request(olce_pkg::FUNC_APPEND, 8'h00, 5'd0);
      send_request(olce_pkg::FUNC_APPEND, 8'hFF, 5'd31);
      send_request(olce_pkg::FUNC_INSERT, 8'h33, 5'd0);   // position zero is bad
      send_request(olce_pkg::FUNC_INSERT, 8'hAA, 5'd1);
      send_request(olce_pkg::FUNC_INSERT, 8'h55, 5'd3);   // position equal to count: append
      send_request(olce_pkg::FUNC_INSERT, 8'h44, 5'd5);   // above count
      send_request(olce_pkg::FUNC_INSERT, 8'h44, 5'd16);
      send_request(olce_pkg::FUNC_SEARCH, 8'hFF, 5'd16);
      send_request(olce_pkg::FUNC_SEARCH, 8'h12, 5'd0);   // miss on non-empty list
      send_request(olce_pkg::FUNC_APPEND, 8'hAA, 5'd0);
      send_request(olce_pkg::FUNC_SEARCH, 8'hAA, 5'd0);   // first of duplicates
      send_request(olce_pkg::FUNC_SEARCH, 8'h00, 5'd0);
      send_request(olce_pkg::FUNC_REMOVE, 8'hFF, 5'd7);
      send_request(olce_pkg::FUNC_SEARCH, 8'h00, 5'd0);
   endtask

   task automatic test_full_list();
      int i;
      while (shadow_count < DEPTH) begin
         if (shadow_count > 0 && $urandom_range(0, 1))
            send_request(olce_pkg::FUNC_INSERT, 8'($urandom),
                         5'($urandom_range(1, shadow_count)));
         else
            send_request(olce_pkg::FUNC_APPEND, 8'($urandom), 5'd0);
      end
      send_request(olce_pkg::FUNC_APPEND, 8'h5A, 5'd0);   // append when full
      send_request(olce_pkg::FUNC_INSERT, 8'h5A, 5'd0);   // full wins over bad position
      send_request(olce_pkg::FUNC_INSERT, 8'h5A, 5'd8);
      send_request(olce_pkg::FUNC_SEARCH, shadow_cells[DEPTH-1], 5'd0);
      send_request(olce_pkg::FUNC_SEARCH, shadow_cells[8], 5'd0);
      for (i = 0; i < DEPTH + 1; i++)
         send_request(olce_pkg::FUNC_REMOVE, 8'($urandom), 5'($urandom_range(0, 16)));
   endtask

   task automatic pick_request(input int fill_target, output logic [1:0] func,
                               output logic [7:0] value, output logic [4:0] position);
      int grow_pct;
      int roll;
      logic [7:0] pool [4];
      pool = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
      value = ($urandom_range(0, 9) < 3) ? pool[$urandom_range(0, 3)] : 8'($urandom);
      position = 5'($urandom_range(0, 16));
      roll = $urandom_range(0, 99);
      grow_pct = (shadow_count < fill_target) ? 75 : 30;
      if (roll < 12) begin
         // noise: any operation, any position from 0 to 16
         func = 2'($urandom);
      end else if (roll < 35) begin
         func = olce_pkg::FUNC_SEARCH;
         if (shadow_count > 0 && $urandom_range(0, 3) != 0)
            value = shadow_cells[$urandom_range(0, shadow_count - 1)];
      end else if ($urandom_range(0, 99) < grow_pct) begin
         if (shadow_count > 0 && $urandom_range(0, 1)) begin
            func = olce_pkg::FUNC_INSERT;
            position = 5'($urandom_range(1, shadow_count));
         end else begin
            func = olce_pkg::FUNC_APPEND;
         end
      end else begin
         func = olce_pkg::FUNC_REMOVE;
      end
   endtask

   task automatic test_random_traffic(input int n_items);
      int i;
      int fill_target;
      logic [1:0] func;
      logic [7:0] value;
      logic [4:0] position;
      fill_target = 0;
      for (i = 0; i < n_items; i++) begin
         if (i % 60 == 0)
            fill_target = ($urandom_range(0, 3) == 0) ? DEPTH : $urandom_range(0, DEPTH);
         pick_request(fill_target, func, value, position);
         send_request(func, value, position);
      end
   endtask

   task automatic test_output_hold_off();
      hold_off_request = 1'b1;
      test_random_traffic(40);
   endtask

   initial begin
      int wait_cycles;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      error_count = 0;
      burst_left = 0;
      hold_off_request = 1'b0;
      shadow_count = 0;
      sender_gaps_on = 1'b1;
      receiver_stalls_on = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      idle_request_bus();
      test_full_list();
      idle_request_bus();

      // no idling on either side
      sender_gaps_on = 1'b0;
      receiver_stalls_on = 1'b0;
      test_random_traffic(100);
      idle_request_bus();

      test_output_hold_off();
      idle_request_bus();

      sender_gaps_on = 1'b1;
      receiver_stalls_on = 1'b1;
      test_random_traffic(400);
      idle_request_bus();

      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0)
         report_error($sformatf("%0d responses never arrived", pending_results.size()));

      if (error_count == 0)
         $display("** ordered_char_list_engine: PASSED **");
      else
         $display("** ordered_char_list_engine: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/olce_pkg.sv
hw/rtl/olce_cell.sv
hw/rtl/ordered_char_list_engine.sv
tb/ordered_char_list_engine_tb.sv
